// ===== hdl/mbet_pkg.sv =====
`default_nettype none

package mbet_pkg;

	// reset value of the round limit register
	localparam logic [7:0] MAX_ITER_RESET = 8'd100;

	// request from the point sequencer to the shared multiplier
	typedef struct packed {
		logic start;  // latch operands and begin a product
		logic dbl;    // shift by one less fraction bit, giving twice the product
	} mul_req_t;

	// shared multiplier sequence
	typedef enum logic [1:0] {
		MS_IDLE,
		MS_LO,
		MS_HI,
		MS_RND
	} mul_state_t;

	// point sequencer
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COORD,
		ST_CSUM,
		ST_CHECK,
		ST_SQR_RE,
		ST_SQR_IM,
		ST_TEST,
		ST_CROSS,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/mandelbrot_escape_time_unit.sv =====
`default_nettype none

// Mandelbrot escape-time unit. Each input beat carries one point as two byte
// codes, mapped to c = -2 + 4*code/255 in signed fixed point with
// FRACTION_BITS fraction bits. The unit iterates z = z*z + c from z = 0 for
// up to max_iterations rounds (register written through cfg_wr_en and
// cfg_wr_data, reset value 100) and returns on one output beat the round
// index at which |z|^2 first exceeded 4, or 0 if it never did. One point is
// handled at a time and in_stall stays high until its result is taken. The
// three products of a round go through a single shared multiplier, which
// forms each product from two partial products, one for each half of an
// operand, followed by a rounding step and a handoff.
module mandelbrot_escape_time_unit #(
	parameter int FRACTION_BITS = 28
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire  [7:0]  cfg_wr_data,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  real_code,
	input  wire  [7:0]  imag_code,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [7:0]  escape_count
);

	localparam int W     = FRACTION_BITS + 4;
	localparam int RW    = FRACTION_BITS + 8;
	localparam int CODE_SH = (FRACTION_BITS + 2) % 8;
	localparam logic [W-1:0] COORD_Q =
		W'((64'd1 << (FRACTION_BITS + 2)) / 64'd255);
	localparam logic signed [W-1:0] COORD_OFS = W'(64'd1 << (FRACTION_BITS + 1));
	localparam logic signed [RW:0] ESC_LIMIT = (RW+1)'(64'd4 << FRACTION_BITS);

	// exact floor(t/255) for 16-bit t: reciprocal estimate plus one correction
	function automatic logic [7:0] div255(input logic [15:0] t);
		logic [23:0] est;
		logic [7:0]  q0;
		logic [15:0] rem;
		est = {8'd0, t} + {t, 8'd0};
		q0  = est[23:16];
		rem = t - 16'({q0, 8'd0} - {8'd0, q0});
		return q0 + 8'(rem >= 16'd255);
	endfunction

	mbet_pkg::state_t   state_q, state_d;
	mbet_pkg::mul_req_t mul_req;

	logic [7:0]             max_iter_q;
	logic [7:0]             real_code_q, imag_code_q;
	logic [W-1:0]           part_r_q, part_i_q;
	logic [7:0]             frac_r_q, frac_i_q;
	logic signed [W-1:0]    cr_q, ci_q, zr_q, zi_q;
	logic signed [RW-1:0]   zr2_q, zi2_q;
	logic [7:0]             iter_q, escape_q;
	logic signed [W-1:0]    mul_a, mul_b;
	logic                   mul_done;
	logic signed [RW-1:0]   mul_res;
	logic signed [RW:0]     mag_sum;
	logic                   escaped;

	// round limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= mbet_pkg::MAX_ITER_RESET;
		end else if (cfg_wr_en) begin
			max_iter_q <= cfg_wr_data;
		end
	end

	// shared multiplier
	mbet_mul #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_res)
	);

	// escape test on the two squares
	assign mag_sum = (RW+1)'(zr2_q) + (RW+1)'(zi2_q);
	assign escaped = mag_sum > ESC_LIMIT;

	// handshake
	assign in_stall     = (state_q != mbet_pkg::ST_IDLE);
	assign out_valid    = (state_q == mbet_pkg::ST_OUT);
	assign escape_count = escape_q;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbet_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and multiplier requests
	always_comb begin
		state_d = state_q;
		mul_req = '0;
		mul_a   = zr_q;
		mul_b   = zr_q;
		case (state_q)
			mbet_pkg::ST_IDLE: begin
				if (in_valid) state_d = mbet_pkg::ST_COORD;
			end
			mbet_pkg::ST_COORD: state_d = mbet_pkg::ST_CSUM;
			mbet_pkg::ST_CSUM:  state_d = mbet_pkg::ST_CHECK;
			mbet_pkg::ST_CHECK: begin
				if (iter_q == max_iter_q) begin
					state_d = mbet_pkg::ST_OUT;
				end else begin
					mul_req.start = 1'b1;
					state_d = mbet_pkg::ST_SQR_RE;
				end
			end
			mbet_pkg::ST_SQR_RE: begin
				mul_a = zi_q;
				mul_b = zi_q;
				if (mul_done) begin
					mul_req.start = 1'b1;
					state_d = mbet_pkg::ST_SQR_IM;
				end
			end
			mbet_pkg::ST_SQR_IM: begin
				if (mul_done) state_d = mbet_pkg::ST_TEST;
			end
			mbet_pkg::ST_TEST: begin
				mul_b = zi_q;
				if (escaped) begin
					state_d = mbet_pkg::ST_OUT;
				end else begin
					mul_req.start = 1'b1;
					mul_req.dbl   = 1'b1;
					state_d = mbet_pkg::ST_CROSS;
				end
			end
			mbet_pkg::ST_CROSS: begin
				if (mul_done) state_d = mbet_pkg::ST_CHECK;
			end
			mbet_pkg::ST_OUT: begin
				if (!out_stall) state_d = mbet_pkg::ST_IDLE;
			end
			default: state_d = mbet_pkg::ST_IDLE;
		endcase
	end

	// point datapath
	always_ff @(posedge clk) begin
		case (state_q)
			mbet_pkg::ST_IDLE: begin
				if (in_valid) begin
					real_code_q <= real_code;
					imag_code_q <= imag_code;
					iter_q      <= '0;
					escape_q    <= '0;
					zr_q        <= '0;
					zi_q        <= '0;
				end
			end
			// code*2^(F+2)/255 split into code*quotient plus a small remainder term
			mbet_pkg::ST_COORD: begin
				part_r_q <= W'(real_code_q * COORD_Q);
				part_i_q <= W'(imag_code_q * COORD_Q);
				frac_r_q <= div255(16'(({8'd0, real_code_q} << CODE_SH) + 16'd127));
				frac_i_q <= div255(16'(({8'd0, imag_code_q} << CODE_SH) + 16'd127));
			end
			mbet_pkg::ST_CSUM: begin
				cr_q <= $signed(part_r_q + W'(frac_r_q)) - COORD_OFS;
				ci_q <= $signed(part_i_q + W'(frac_i_q)) - COORD_OFS;
			end
			mbet_pkg::ST_SQR_RE: begin
				if (mul_done) zr2_q <= mul_res;
			end
			mbet_pkg::ST_SQR_IM: begin
				if (mul_done) zi2_q <= mul_res;
			end
			mbet_pkg::ST_TEST: begin
				if (escaped) escape_q <= iter_q;
			end
			// z update once the cross product is back
			mbet_pkg::ST_CROSS: begin
				if (mul_done) begin
					zi_q   <= W'(mul_res + RW'(ci_q));
					zr_q   <= W'(zr2_q - zi2_q + RW'(cr_q));
					iter_q <= iter_q + 8'd1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/mbet_mul.sv =====
`default_nettype none

module mbet_mul #(
	parameter int FRACTION_BITS = 28
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire mbet_pkg::mul_req_t            req,
	input  wire signed [FRACTION_BITS+3:0]     a,
	input  wire signed [FRACTION_BITS+3:0]     b,
	output logic                               done,
	output logic signed [FRACTION_BITS+7:0]    product
);

	localparam int W  = FRACTION_BITS + 4;
	localparam int RW = FRACTION_BITS + 8;
	localparam int PW = 2 * W;
	localparam int LW = (W + 1) / 2;
	localparam int HW = W - LW;

	mbet_pkg::mul_state_t state_q, state_d;

	logic [W-1:0]       a_mag_q, b_mag_q;
	logic               neg_q, dbl_q;
	logic [PW-1:0]      acc_q;
	logic [W-1:0]       a_abs, b_abs;
	logic [W+LW-1:0]    pp_lo;
	logic [W+HW-1:0]    pp_hi;
	logic [PW-1:0]      sh_f, sh_d;
	logic [RW-1:0]      q_mag, q_rnd;
	logic               rem_nz;

	// operand magnitudes
	assign a_abs = a[W-1] ? W'(-a) : W'(a);
	assign b_abs = b[W-1] ? W'(-b) : W'(b);

	// partial products of the full magnitude with each half of the other
	assign pp_lo = a_mag_q * b_mag_q[LW-1:0];
	assign pp_hi = a_mag_q * b_mag_q[W-1:LW];

	// floor rounding of the signed product after the right shift
	assign sh_f   = acc_q >> FRACTION_BITS;
	assign sh_d   = acc_q >> (FRACTION_BITS - 1);
	assign q_mag  = dbl_q ? sh_d[RW-1:0] : sh_f[RW-1:0];
	assign rem_nz = dbl_q ? (|acc_q[FRACTION_BITS-2:0]) : (|acc_q[FRACTION_BITS-1:0]);
	assign q_rnd  = q_mag + RW'(neg_q & rem_nz);

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbet_pkg::MS_IDLE;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == mbet_pkg::MS_RND);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mbet_pkg::MS_IDLE: begin
				if (req.start) state_d = mbet_pkg::MS_LO;
			end
			mbet_pkg::MS_LO:  state_d = mbet_pkg::MS_HI;
			mbet_pkg::MS_HI:  state_d = mbet_pkg::MS_RND;
			mbet_pkg::MS_RND: state_d = mbet_pkg::MS_IDLE;
			default:          state_d = mbet_pkg::MS_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			mbet_pkg::MS_IDLE: begin
				if (req.start) begin
					a_mag_q <= a_abs;
					b_mag_q <= b_abs;
					neg_q   <= a[W-1] ^ b[W-1];
					dbl_q   <= req.dbl;
				end
			end
			mbet_pkg::MS_LO: begin
				acc_q <= PW'(pp_lo);
			end
			mbet_pkg::MS_HI: begin
				acc_q <= acc_q + (PW'(pp_hi) << LW);
			end
			mbet_pkg::MS_RND: begin
				product <= neg_q ? $signed(-q_rnd) : $signed(q_rnd);
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
